// ===== hdl/hed_pkg.sv =====
// Shared types, constants and helpers for the hex escape decoder.
// No dependencies; every other file in hdl/ refers to this package.
package hed_pkg;

    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_X        = 8'h78;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;
    localparam int         QUEUE_DEPTH = 4;

    localparam logic [7:0] PREFIX [4] = '{CH_UNDER, CH_UNDER, CH_X, CH_UNDER};

    typedef enum logic [2:0] {
        PFX_IDLE  = 3'd0,
        PFX_U1    = 3'd1,
        PFX_U2    = 3'd2,
        PFX_X     = 3'd3,
        PFX_U3    = 3'd4,
        PFX_DIGIT = 3'd5
    } pfx_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_end;
    } out_item_t;

    typedef struct packed {
        logic [2:0] held;
        logic [7:0] tail;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    function automatic logic [7:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (b inside {[8'h30:8'h39]})
        begin
            v = b - 8'h30;
        end
        else if (b inside {[8'h61:8'h66]})
        begin
            v = b - 8'h57;
        end
        else if (b inside {[8'h41:8'h46]})
        begin
            v = b - 8'h37;
        end
        return v;
    endfunction

endpackage

// ===== hdl/hed_front.sv =====
// Front end of the hex escape decoder: tracks the escape prefix and turns
// accepted requests into emit requests for the back end. Uses hed_pkg.
module hed_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  hed_pkg::in_item_t item,
    output logic             cmd_push,
    output hed_pkg::cmd_t    cmd
);

    hed_pkg::pfx_state_t state_reg, state_next;
    logic [7:0]          first_digit_reg, first_digit_next;
    logic [7:0]          hv;
    logic [2:0]          held_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hed_pkg::PFX_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_digit_reg <= first_digit_next;
    end

    always_comb
    begin
        hv = hed_pkg::hex_value(item.in_byte);
        case (state_reg)
            hed_pkg::PFX_U1: held_cnt = 3'd1;
            hed_pkg::PFX_U2: held_cnt = 3'd2;
            hed_pkg::PFX_X:  held_cnt = 3'd3;
            hed_pkg::PFX_U3: held_cnt = 3'd4;
            default:         held_cnt = 3'd0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        first_digit_next = first_digit_reg;
        cmd_push         = 1'b0;
        cmd.held         = 3'd0;
        cmd.tail         = item.in_byte;
        cmd.last         = item.is_last;
        if (accept)
        begin
            if (state_reg == hed_pkg::PFX_DIGIT)
            begin
                cmd.tail   = {first_digit_reg[3:0], 4'b0000} | (hv & hed_pkg::NIBBLE_MASK);
                cmd_push   = 1'b1;
                state_next = hed_pkg::PFX_IDLE;
            end
            else if (item.is_last)
            begin
                cmd.held   = held_cnt;
                cmd_push   = 1'b1;
                state_next = hed_pkg::PFX_IDLE;
            end
            else
            begin
                case (state_reg)
                    hed_pkg::PFX_IDLE:
                    begin
                        if (item.in_byte == hed_pkg::CH_UNDER)
                        begin
                            state_next = hed_pkg::PFX_U1;
                        end
                        else
                        begin
                            cmd_push = 1'b1;
                        end
                    end
                    hed_pkg::PFX_U1:
                    begin
                        if (item.in_byte == hed_pkg::CH_UNDER)
                        begin
                            state_next = hed_pkg::PFX_U2;
                        end
                        else
                        begin
                            cmd.held   = held_cnt;
                            cmd_push   = 1'b1;
                            state_next = hed_pkg::PFX_IDLE;
                        end
                    end
                    hed_pkg::PFX_U2:
                    begin
                        if (item.in_byte == hed_pkg::CH_X)
                        begin
                            state_next = hed_pkg::PFX_X;
                        end
                        else if (item.in_byte == hed_pkg::CH_UNDER)
                        begin
                            cmd_push = 1'b1;
                        end
                        else
                        begin
                            cmd.held   = held_cnt;
                            cmd_push   = 1'b1;
                            state_next = hed_pkg::PFX_IDLE;
                        end
                    end
                    hed_pkg::PFX_X:
                    begin
                        if (item.in_byte == hed_pkg::CH_UNDER)
                        begin
                            state_next = hed_pkg::PFX_U3;
                        end
                        else
                        begin
                            cmd.held   = held_cnt;
                            cmd_push   = 1'b1;
                            state_next = hed_pkg::PFX_IDLE;
                        end
                    end
                    hed_pkg::PFX_U3:
                    begin
                        first_digit_next = hv;
                        state_next       = hed_pkg::PFX_DIGIT;
                    end
                    default:
                    begin
                        cmd_push   = 1'b1;
                        state_next = hed_pkg::PFX_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/hed_queue.sv =====
// Short queue of emit requests between front and back of the decoder.
// Uses hed_pkg for the request type.
module hed_queue #(
    parameter int DEPTH = hed_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  hed_pkg::cmd_t    wr_cmd,
    input  logic             rd_en,
    output hed_pkg::q_head_t head,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hed_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    wr_not_full_a: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("emit request pushed into a full queue");

    count_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    count_track_a: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a write");

endmodule

// ===== hdl/hed_back.sv =====
// Back end (uses hed_pkg): expands each emit request into held prefix bytes
// and a final byte to the result register, one per cycle while it is free.
module hed_back (
    input  logic               clk,
    input  logic               rst_n,
    input  hed_pkg::q_head_t   head,
    output logic               deq,
    input  logic               pop,
    output logic               empty,
    output hed_pkg::out_item_t result
);

    logic [2:0]         k_reg, k_next;
    logic               valid_reg, valid_next;
    hed_pkg::out_item_t res_reg, res_next;
    logic               load, emit, at_tail;

    assign load    = !valid_reg || pop;
    assign emit    = head.valid && load;
    assign at_tail = (k_reg >= head.cmd.held);
    assign deq     = emit && at_tail;
    assign empty   = !valid_reg;
    assign result  = res_reg;

    always_comb
    begin
        k_next     = k_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next = emit;
        end
        if (emit)
        begin
            if (at_tail)
            begin
                res_next.out_byte   = head.cmd.tail;
                res_next.run_last   = 1'b1;
                res_next.stream_end = head.cmd.last;
                k_next              = 3'd0;
            end
            else
            begin
                res_next.out_byte   = hed_pkg::PREFIX[k_reg[1:0]];
                res_next.run_last   = 1'b0;
                res_next.stream_end = 1'b0;
                k_next              = k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    k_in_request_a: assert property (@(posedge clk) disable iff (!rst_n)
        (k_reg != 3'd0) |-> (head.valid && (k_reg <= head.cmd.held)))
        else $error("prefix index outside the current request");

    end_is_final_a: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.stream_end) |-> res_reg.run_last)
        else $error("stream end on a non-final byte");

    held_is_prefix_a: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !res_reg.run_last) |->
            (res_reg.out_byte == hed_pkg::CH_UNDER || res_reg.out_byte == hed_pkg::CH_X))
        else $error("held byte is not a prefix character");

endmodule

// ===== hdl/hex_escape_decoder.sv =====
// An accepted request reaches the result ports through the request queue and the result register.
// One request is accepted per cycle while each yields at most one byte and the
// result is popped; a request that releases n held bytes makes the back end emit n + 1 bytes.
// The QUEUE_DEPTH-entry request queue lets the front keep accepting meanwhile.
// Reset (rst_n low, asynchronous) clears the prefix tracker and queue and empties the result.
// Uses hed_pkg; instantiates hed_front, hed_queue and hed_back.
module hex_escape_decoder #(
    parameter int QUEUE_DEPTH = hed_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  hed_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output hed_pkg::out_item_t result
);

    logic             accept;
    logic             cmd_push;
    hed_pkg::cmd_t    cmd;
    hed_pkg::q_head_t head;
    logic             deq;

    assign accept = push && !full;

    hed_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    hed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (cmd),
        .rd_en  (deq),
        .head   (head),
        .full   (full)
    );

    hed_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .deq    (deq),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule
